// ===== design/ppa_pkg.sv =====
package ppa_pkg;
  localparam int PARTITIONS = 64;
  localparam int IDX_W = 6;
  localparam int CNT_W = 7;
  localparam int OWNER_W = 6;
  localparam logic [OWNER_W-1:0] MAX_OWNER = 6'd62;
  localparam logic [OWNER_W-1:0] OWNER_FREE = 6'd63;

  typedef enum logic [1:0] {
    OP_GROW = 2'd0,
    OP_NEW  = 2'd1,
    OP_FREE = 2'd2,
    OP_BAD  = 2'd3
  } op_t;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NO_ROOM = 3'd1;
  localparam logic [2:0] ST_TOO_FEW = 3'd2;
  localparam logic [2:0] ST_HOST    = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  // Sweep control; only shift goes to every cell, the rest acts at the ring head.
  typedef struct packed {
    logic                  shift;   // rotate ring by one
    logic                  wr_en;   // rewrite the entry leaving position 0
    logic [OWNER_W-1:0]    match;   // owner compared for a free sweep
    logic                  do_free; // replace matching entries by free code
    logic [IDX_W-1:0]      lo;      // write window, inclusive
    logic [CNT_W-1:0]      hi;      // write window end, exclusive
    logic [OWNER_W-1:0]    wval;
  } cell_ctl_t;
endpackage

// ===== design/partition_pool_allocator.sv =====
// Partition pool allocator. The ownership table is a ring of 64 cells; each
// pass rotates the ring once around while a scanner watches the entry at
// the head. A grow or new request sweeps twice: a scan pass that measures
// free runs, then a write pass that stamps the chosen range as the ring
// goes by. A free request needs one pass that releases and counts matching
// entries. A grow or new that finds no room answers after the scan pass.
// One request is worked at a time, and the next is taken only once the
// result beat has left the output register. Requests that fail a check
// before the scan (too few free, host owner, bad region, unknown op) answer
// straight from the check state that follows acceptance.
// The user writes host_owner_id through cfg_we / cfg_data only while idle;
// the block itself does not enforce this.
module partition_pool_allocator (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [5:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_op,
  input  logic [5:0] in_owner_id,
  input  logic [6:0] in_count,
  input  logic [5:0] in_region_start,
  input  logic [6:0] in_region_length,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_status,
  output logic [5:0] out_first_index,
  output logic [6:0] out_largest_free_run,
  output logic [6:0] out_freed_count
);
  localparam int N = ppa_pkg::PARTITIONS;
  localparam int IW = ppa_pkg::IDX_W;
  localparam int CW = ppa_pkg::CNT_W;
  localparam int OW = ppa_pkg::OWNER_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_SCAN  = 5'b00100,
    S_WRITE = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [OW-1:0] host_r;
  logic [CW-1:0] free_cnt_r, free_cnt_nxt;

  // request registers
  logic [1:0]    op_r;
  logic [OW-1:0] own_r;
  logic [CW-1:0] cnt_r, rlen_r;
  logic [IW-1:0] rst_r;

  // sweep position: index of the entry currently at the ring head
  logic [CW-1:0] pos_r, pos_nxt;

  // scan bookkeeping
  logic          in_run_r, in_run_nxt;
  logic [CW-1:0] head_r, head_nxt;
  logic [CW-1:0] best_len_r, best_len_nxt, best_head_r, best_head_nxt;
  logic [CW-1:0] left_r, left_nxt, right_r, right_nxt;
  logic          rdone_r, rdone_nxt;
  logic [CW-1:0] freed_r, freed_nxt;

  logic [IW-1:0] first_r, first_nxt;

  // output register
  logic          ov_r;
  logic [2:0]    st_o_r, st_o_nxt;
  logic [IW-1:0] fi_o_r, fi_o_nxt;
  logic [CW-1:0] run_o_r, run_o_nxt, fr_o_r, fr_o_nxt;
  logic          load_out;

  ppa_pkg::cell_ctl_t ctl;

  // ring of cells
  logic [OW-1:0] cq   [N];
  logic [OW-1:0] cd   [N];
  logic [OW-1:0] head_val, head_new;

  assign head_val = cq[0];

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_ring
      if (g == N - 1) begin : g_last
        assign cd[g] = head_new;
      end else begin : g_mid
        assign cd[g] = cq[g+1];
      end
      ppa_cell u_cell (
        .clk  (clk),
        .rst_n(rst_n),
        .shift(ctl.shift),
        .d_in (cd[g]),
        .q    (cq[g])
      );
    end
  endgenerate

  // value recirculated from the head: stamp window or release owner
  always_comb begin
    head_new = head_val;
    if (ctl.do_free && head_val == ctl.match) begin
      head_new = ppa_pkg::OWNER_FREE;
    end else if (ctl.wr_en && {1'b0, pos_r[IW-1:0]} >= {1'b0, ctl.lo}
                 && pos_r < ctl.hi) begin
      head_new = ctl.wval;
    end
  end

  assign in_ready = (state_r == S_IDLE) && !ov_r;

  wire head_free = (head_val == ppa_pkg::OWNER_FREE);
  wire last_pos  = (pos_r == CW'(N - 1));
  wire [CW-1:0] top = CW'(rst_r) + rlen_r;
  // region end one bit wider so a long region cannot wrap past the check
  wire [CW:0] top_wide = {1'b0, CW'(rst_r)} + {1'b0, rlen_r};

  logic [CW-1:0] below, above, run_len, new_off;
  logic          bad;

  always_comb begin
    state_nxt     = state_r;
    free_cnt_nxt  = free_cnt_r;
    pos_nxt       = pos_r;
    in_run_nxt    = in_run_r;
    head_nxt      = head_r;
    best_len_nxt  = best_len_r;
    best_head_nxt = best_head_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    rdone_nxt     = rdone_r;
    freed_nxt     = freed_r;
    first_nxt     = first_r;
    load_out      = 1'b0;
    st_o_nxt      = ppa_pkg::ST_NO_ROOM;
    fi_o_nxt      = '0;
    run_o_nxt     = '0;
    fr_o_nxt      = '0;
    ctl           = '0;
    ctl.match     = own_r;
    ctl.lo        = first_r;
    ctl.hi        = CW'(first_r) + cnt_r;
    ctl.wval      = own_r;
    below         = CW'(rst_r) - left_r;
    above         = right_r - top;
    run_len       = pos_r - head_r;
    new_off       = (best_len_r - cnt_r) >> 1;
    bad           = (rlen_r == '0) || (top_wide > (CW+1)'(N));

    case (state_r)
      S_IDLE: begin
        pos_nxt      = '0;
        in_run_nxt   = 1'b0;
        head_nxt     = '0;
        best_len_nxt = '0;
        best_head_nxt = '0;
        left_nxt     = '0;
        right_nxt    = CW'(N);
        rdone_nxt    = 1'b0;
        freed_nxt    = '0;
        if (in_valid && in_ready) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        // early verdicts before touching the table
        if (op_r == ppa_pkg::OP_BAD) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end else if (op_r == ppa_pkg::OP_FREE) begin
          if (own_r > ppa_pkg::MAX_OWNER) begin
            st_o_nxt  = ppa_pkg::ST_OK;
            load_out  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_WRITE;
          end
        end else if (cnt_r > free_cnt_r) begin
          st_o_nxt  = ppa_pkg::ST_TOO_FEW;
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end else if (own_r == host_r || own_r > ppa_pkg::MAX_OWNER) begin
          st_o_nxt  = ppa_pkg::ST_HOST;
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end else if (op_r == ppa_pkg::OP_GROW && bad) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        ctl.shift = 1'b1;
        pos_nxt   = pos_r + 1'b1;
        if (op_r == ppa_pkg::OP_GROW) begin
          // left edge: last non-free index below region start, plus one
          if (pos_r < CW'(rst_r) && !head_free) left_nxt = pos_r + 1'b1;
          // right edge: first non-free index at or above top
          if (pos_r >= top && !head_free && !rdone_r) begin
            right_nxt = pos_r;
            rdone_nxt = 1'b1;
          end
        end else begin
          if (head_free) begin
            if (!in_run_r) begin
              head_nxt   = pos_r;
              in_run_nxt = 1'b1;
            end
          end else if (in_run_r) begin
            in_run_nxt = 1'b0;
            if (run_len > best_len_r) begin
              best_len_nxt  = run_len;
              best_head_nxt = head_r;
            end
          end
          if (last_pos && (head_free || in_run_r)) begin
            // run closes at the end of the table
            if (!in_run_r) begin
              if (CW'(1) > best_len_r) begin
                best_len_nxt  = CW'(1);
                best_head_nxt = pos_r;
              end
            end else if (head_free && (CW'(N) - head_r > best_len_r)) begin
              best_len_nxt  = CW'(N) - head_r;
              best_head_nxt = head_r;
            end
          end
        end
        if (last_pos) begin
          pos_nxt   = '0;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // decide placement from the scan
        if (op_r == ppa_pkg::OP_GROW) begin
          if (below > above) begin
            if (below >= cnt_r) begin
              first_nxt = IW'(CW'(rst_r) - cnt_r);
              state_nxt = S_WRITE;
            end else begin
              load_out = 1'b1;
              state_nxt = S_IDLE;
            end
          end else if (above >= cnt_r) begin
            first_nxt = top[IW-1:0];
            state_nxt = S_WRITE;
          end else begin
            load_out  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          if (best_len_r >= cnt_r && best_len_r != '0) begin
            first_nxt = IW'(best_head_r + new_off);
            state_nxt = S_WRITE;
          end else begin
            run_o_nxt = best_len_r;
            st_o_nxt  = (best_len_r == '0) ? ppa_pkg::ST_FULL : ppa_pkg::ST_NO_ROOM;
            load_out  = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_WRITE: begin
        ctl.shift = 1'b1;
        pos_nxt   = pos_r + 1'b1;
        if (op_r == ppa_pkg::OP_FREE) begin
          ctl.do_free = 1'b1;
          if (head_val == own_r) freed_nxt = freed_r + 1'b1;
        end else begin
          ctl.wr_en = 1'b1;
        end
        if (last_pos) begin
          load_out  = 1'b1;
          st_o_nxt  = ppa_pkg::ST_OK;
          state_nxt = S_IDLE;
          if (op_r == ppa_pkg::OP_FREE) begin
            fr_o_nxt     = freed_nxt;
            free_cnt_nxt = free_cnt_r + freed_nxt;
          end else begin
            fi_o_nxt     = first_r;
            free_cnt_nxt = free_cnt_r - cnt_r;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      host_r     <= '0;
      free_cnt_r <= CW'(N);
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      free_cnt_r <= free_cnt_nxt;
      if (cfg_we) host_r <= cfg_data;
      // hold the result beat until taken
      if (load_out) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    in_run_r    <= in_run_nxt;
    head_r      <= head_nxt;
    best_len_r  <= best_len_nxt;
    best_head_r <= best_head_nxt;
    left_r      <= left_nxt;
    right_r     <= right_nxt;
    rdone_r     <= rdone_nxt;
    freed_r     <= freed_nxt;
    first_r     <= first_nxt;
    if (in_valid && in_ready) begin
      op_r   <= in_op;
      own_r  <= in_owner_id;
      cnt_r  <= in_count;
      rst_r  <= in_region_start;
      rlen_r <= in_region_length;
    end
    if (load_out) begin
      st_o_r  <= st_o_nxt;
      fi_o_r  <= fi_o_nxt;
      run_o_r <= run_o_nxt;
      fr_o_r  <= fr_o_nxt;
    end
  end

  assign out_valid            = ov_r;
  assign out_status           = st_o_r;
  assign out_first_index      = fi_o_r;
  assign out_largest_free_run = run_o_r;
  assign out_freed_count      = fr_o_r;

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_cnt_r <= CW'(N)) else $error("free count above pool size");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("accept while busy");
  a_load_once: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> state_r == S_IDLE) else $error("result without return to idle");
  a_ring_still: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |=> $stable(free_cnt_r) || $past(state_r) != S_IDLE)
    else $error("free count moved while idle");
endmodule

// ===== design/ppa_cell.sv =====
module ppa_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      shift,
  input  logic [ppa_pkg::OWNER_W-1:0] d_in,
  output logic [ppa_pkg::OWNER_W-1:0] q
);
  logic [ppa_pkg::OWNER_W-1:0] q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= ppa_pkg::OWNER_FREE;
    end else if (shift) begin
      q_r <= d_in;
    end
  end

  assign q = q_r;
endmodule

// ===== tb/partition_pool_allocator_tb.sv =====
`timescale 1ns / 1ps

module partition_pool_allocator_tb;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct {
    ppa_pkg::op_t     op;
    logic [5:0]       owner;
    logic [6:0]       count;
    logic [5:0]       rstart;
    logic [6:0]       rlen;
  } request_t;

  typedef struct {
    logic [2:0] status;
    logic [5:0] first;
    logic [6:0] run;
    logic [6:0] freed;
  } answer_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [5:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_op = '0;
  logic [5:0] in_owner_id = '0;
  logic [6:0] in_count = '0;
  logic [5:0] in_region_start = '0;
  logic [6:0] in_region_length = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] out_status;
  logic [5:0] out_first_index;
  logic [6:0] out_largest_free_run;
  logic [6:0] out_freed_count;

  partition_pool_allocator i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_op(in_op), .in_owner_id(in_owner_id), .in_count(in_count),
    .in_region_start(in_region_start), .in_region_length(in_region_length),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_first_index(out_first_index),
    .out_largest_free_run(out_largest_free_run), .out_freed_count(out_freed_count)
  );

  // Shadow copy of the pool, kept in step with accepted requests.
  logic [5:0] pool_owner [ppa_pkg::PARTITIONS];
  int         pool_free;
  logic [5:0] host_id;

  request_t   pending_reqs[$];
  answer_t    awaited_answers[$];
  int         errors = 0;
  int         sender_idle_pct = 0;
  int         receiver_stall_pct = 0;
  bit         sender_hold = 1'b0;
  int         cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // Mark n partitions from 'from' with the owner, clipped at the pool end.
  function automatic void stamp(input int from, input int n, input logic [5:0] who);
    for (int i = 0; i < n && from + i < ppa_pkg::PARTITIONS; i++)
      pool_owner[from + i] = who;
  endfunction

  // Apply one request to the shadow pool and return the answer it must give.
  function automatic answer_t allocate(input request_t r);
    answer_t a;
    int n, bottom, top, left, right, below, above;
    int head, best_head, best_len;
    bit in_run, placed;
    a = '{ppa_pkg::ST_NO_ROOM, 6'd0, 7'd0, 7'd0};
    n = int'(r.count);
    case (r.op)
      ppa_pkg::OP_FREE: begin
        a.status = ppa_pkg::ST_OK;
        if (r.owner <= ppa_pkg::MAX_OWNER) begin
          for (int i = 0; i < ppa_pkg::PARTITIONS; i++) begin
            if (pool_owner[i] == r.owner) begin
              pool_owner[i] = ppa_pkg::OWNER_FREE;
              a.freed++;
            end
          end
          pool_free += int'(a.freed);
        end
      end
      ppa_pkg::OP_GROW, ppa_pkg::OP_NEW: begin
        if (n > pool_free) begin
          a.status = ppa_pkg::ST_TOO_FEW;
        end else if (r.owner == host_id || r.owner > ppa_pkg::MAX_OWNER) begin
          a.status = ppa_pkg::ST_HOST;
        end else if (r.op == ppa_pkg::OP_GROW) begin
          bottom = int'(r.rstart);
          top = int'(r.rstart) + int'(r.rlen);
          if (r.rlen != 0 && top <= ppa_pkg::PARTITIONS) begin
            left = bottom;
            right = top;
            placed = 1'b0;
            // The downward scan stops at partition zero.
            while (left > 0 && pool_owner[left - 1] == ppa_pkg::OWNER_FREE) left--;
            while (right < ppa_pkg::PARTITIONS && pool_owner[right] == ppa_pkg::OWNER_FREE)
              right++;
            below = bottom - left;
            above = right - top;
            if (below > above) begin
              if (below >= n) begin
                a.first = 6'(bottom - n);
                placed = 1'b1;
              end
            end else if (above >= n) begin
              a.first = 6'(top);
              placed = 1'b1;
            end
            if (placed) begin
              stamp(int'(a.first), n, r.owner);
              pool_free -= n;
              a.status = ppa_pkg::ST_OK;
            end else begin
              a.first = '0;
            end
          end
        end else begin
          head = 0;
          best_head = 0;
          best_len = 0;
          in_run = 1'b0;
          for (int i = 0; i < ppa_pkg::PARTITIONS; i++) begin
            if (pool_owner[i] == ppa_pkg::OWNER_FREE) begin
              if (!in_run) begin
                head = i;
                in_run = 1'b1;
              end
            end else if (in_run) begin
              in_run = 1'b0;
              if (i - head > best_len) begin
                best_len = i - head;
                best_head = head;
              end
            end
          end
          if (in_run && ppa_pkg::PARTITIONS - head > best_len) begin
            best_len = ppa_pkg::PARTITIONS - head;
            best_head = head;
          end
          if (best_len >= n && best_len != 0) begin
            a.first = 6'(best_head + ((best_len - n) >> 1));
            stamp(int'(a.first), n, r.owner);
            pool_free -= n;
            a.status = ppa_pkg::ST_OK;
          end else begin
            a.run = 7'(best_len);
            a.status = (best_len == 0) ? ppa_pkg::ST_FULL : ppa_pkg::ST_NO_ROOM;
          end
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  // Driver: hold a beat until accepted, predict on acceptance, idle at random.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        awaited_answers.push_back(allocate('{ppa_pkg::op_t'(in_op), in_owner_id, in_count,
                                             in_region_start, in_region_length}));
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() > 0 && !sender_hold &&
            $urandom_range(99) >= sender_idle_pct) begin
          request_t r;
          r = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_op <= r.op;
          in_owner_id <= r.owner;
          in_count <= r.count;
          in_region_start <= r.rstart;
          in_region_length <= r.rlen;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result beat against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_answers.size() == 0) begin
          report("unexpected beat, status", out_status, 0);
        end else begin
          answer_t w;
          w = awaited_answers.pop_front();
          if (out_status !== w.status) report("status", out_status, w.status);
          if (out_first_index !== w.first) report("first_index", out_first_index, w.first);
          if (out_largest_free_run !== w.run)
            report("largest_free_run", out_largest_free_run, w.run);
          if (out_freed_count !== w.freed) report("freed_count", out_freed_count, w.freed);
        end
      end
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  task automatic push(input ppa_pkg::op_t op, input int owner, input int count,
                      input int rstart, input int rlen);
    pending_reqs.push_back('{op, owner[5:0], count[6:0], rstart[5:0], rlen[6:0]});
  endtask

  // Mostly well-formed traffic with small sizes; the rest is noise.
  function automatic request_t random_request();
    request_t r;
    int pick, len;
    pick = int'($urandom_range(99));
    r.owner = 6'($urandom_range(1, 8));
    r.count = 7'($urandom_range(1, 8));
    len = int'($urandom_range(1, 8));
    r.rlen = 7'(len);
    r.rstart = 6'($urandom_range(0, ppa_pkg::PARTITIONS - len));
    if (pick < 35) begin
      r.op = ppa_pkg::OP_NEW;
    end else if (pick < 65) begin
      r.op = ppa_pkg::OP_GROW;
    end else if (pick < 85) begin
      r.op = ppa_pkg::OP_FREE;
    end else begin
      // Noise: any op, full-width fields.
      r.op = ppa_pkg::op_t'($urandom_range(3));
      r.owner = 6'($urandom_range(63));
      r.count = 7'($urandom_range(127));
      r.rstart = 6'($urandom_range(63));
      r.rlen = 7'($urandom_range(127));
    end
    if ($urandom_range(19) == 0) r.count = 7'($urandom_range(0, 64));
    return r;
  endfunction

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || in_valid || awaited_answers.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_host(input logic [5:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    host_id = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int n, input int idle, input int stall);
    sender_idle_pct = idle;
    receiver_stall_pct = stall;
    for (int i = 0; i < n; i++) pending_reqs.push_back(random_request());
    wait_idle();
  endtask

  initial begin
    for (int i = 0; i < ppa_pkg::PARTITIONS; i++) pool_owner[i] = ppa_pkg::OWNER_FREE;
    pool_free = ppa_pkg::PARTITIONS;
    host_id = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    write_host(6'd0);

    // Directed opening: refusals, full pool, centring, both grow sides.
    push(ppa_pkg::OP_FREE, 1, 0, 0, 0);     // nothing to release
    push(ppa_pkg::OP_NEW, 0, 4, 0, 0);      // host owner refused
    push(ppa_pkg::OP_NEW, 5, 0, 0, 0);      // zero count with free space
    push(ppa_pkg::OP_NEW, 1, 64, 0, 0);     // take the whole pool
    push(ppa_pkg::OP_NEW, 2, 0, 0, 0);      // zero count, pool full
    push(ppa_pkg::OP_NEW, 2, 1, 0, 0);      // too few free
    push(ppa_pkg::OP_GROW, 2, 0, 63, 1);    // grow zero count at the top edge
    push(ppa_pkg::OP_FREE, 1, 0, 0, 0);     // release all 64
    push(ppa_pkg::OP_NEW, 3, 10, 0, 0);     // centred in the whole pool
    push(ppa_pkg::OP_GROW, 3, 5, 27, 10);   // tie between sides goes above
    push(ppa_pkg::OP_GROW, 3, 30, 27, 15);  // lower gap chosen but too short
    push(ppa_pkg::OP_GROW, 4, 20, 27, 15);  // lower side wins
    push(ppa_pkg::OP_GROW, 3, 2, 0, 0);     // empty region
    push(ppa_pkg::OP_GROW, 3, 2, 60, 10);   // region past the end
    push(ppa_pkg::OP_GROW, 4, 1, 0, 1);     // downward scan at partition zero
    push(ppa_pkg::OP_BAD, 62, 127, 63, 127);
    push(ppa_pkg::OP_NEW, 63, 1, 0, 0);     // free code as owner
    push(ppa_pkg::OP_FREE, 63, 0, 0, 0);
    push(ppa_pkg::OP_NEW, 62, 100, 0, 0);   // count beyond pool
    push(ppa_pkg::OP_NEW, 62, 40, 0, 0);    // too few free
    push(ppa_pkg::OP_GROW, 62, 64, 0, 64);
    push(ppa_pkg::OP_FREE, 3, 0, 0, 0);
    push(ppa_pkg::OP_FREE, 4, 0, 0, 0);
    wait_idle();

    run_phase(225, 0, 0);
    write_host(6'd62);
    // Pause the sender mid-phase until the pool has answered everything.
    sender_idle_pct = 56;
    receiver_stall_pct = 0;
    for (int i = 0; i < 100; i++) pending_reqs.push_back(random_request());
    while (pending_reqs.size() > 50) @(posedge clk);
    sender_hold = 1'b1;
    while (in_valid || awaited_answers.size() > 0) @(posedge clk);
    sender_hold = 1'b0;
    run_phase(125, 56, 0);
    write_host(6'd63);
    run_phase(225, 0, 56);
    write_host(6'd3);
    run_phase(225, 24, 24);

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
design/ppa_pkg.sv
design/ppa_cell.sv
design/partition_pool_allocator.sv
tb/partition_pool_allocator_tb.sv
